// ----- src/lhgg_pkg.sv -----
// Shared types and constants for the layered hue gradient generator.
// Used by lhgg_ctrl, lhgg_dp and the top level; no dependencies.

package lhgg_pkg;

   localparam logic OP_RENDER = 1'b0;
   localparam logic OP_KEY    = 1'b1;

   localparam logic KIND_COLOR = 1'b0;
   localparam logic KIND_KEY   = 1'b1;

   localparam logic [1:0] REG_NUM_SEGMENTS   = 2'd0;
   localparam logic [1:0] REG_HUE_KEY_STEP   = 2'd1;
   localparam logic [1:0] REG_LEVEL_KEY_STEP = 2'd2;

   localparam logic [7:0] KEY_HUE_UP    = 8'h63;  // c
   localparam logic [7:0] KEY_HUE_DOWN  = 8'h43;  // C
   localparam logic [7:0] KEY_SAT_UP    = 8'h76;  // v
   localparam logic [7:0] KEY_SAT_DOWN  = 8'h56;  // V
   localparam logic [7:0] KEY_BRT_UP    = 8'h62;  // b
   localparam logic [7:0] KEY_BRT_DOWN  = 8'h42;  // B
   localparam logic [7:0] KEY_SHIFT_UP  = 8'h77;  // w
   localparam logic [7:0] KEY_SHIFT_DN  = 8'h65;  // e
   localparam logic [7:0] KEY_STRIDE_UP = 8'h66;  // f
   localparam logic [7:0] KEY_STRIDE_DN = 8'h73;  // s
   localparam logic [7:0] KEY_FREEZE    = 8'h64;  // d

   localparam logic [15:0] NO_SETTING = 16'hFFFF;

   localparam logic [5:0] NUM_SEGMENTS_RESET = 6'd16;
   localparam logic [7:0] KEY_STEP_RESET     = 8'd10;
   localparam logic [7:0] LEVEL_RESET        = 8'd255;
   localparam logic [7:0] STRIDE_RESET       = 8'd40;
   localparam int         HUE_SPACING        = 128;
   localparam int         RESULT_CAP         = 32;

   typedef enum logic {
      ST_IDLE,
      ST_RENDER
   } state_type;

   typedef struct packed {
      logic ready;
      logic accept;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic render_go;
      logic last_seg;
   } dp_status_type;

   typedef struct packed {
      logic        kind;
      logic        last;
      logic [4:0]  segment_index;
      logic [7:0]  hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
      logic [15:0] setting_value;
      logic        key_known;
   } rsp_payload_type;

endpackage

// ----- src/lhgg_ctrl.sv -----
// Controller for the layered hue gradient generator: idle/render sequencing.
// Depends on lhgg_pkg.

module lhgg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  lhgg_pkg::dp_status_type status,
   output lhgg_pkg::ctrl_cmd_type  cmd
);

   lhgg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lhgg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lhgg_pkg::ST_IDLE: begin
            if (req_tvalid && status.out_free && status.render_go) begin
               state_in = lhgg_pkg::ST_RENDER;
            end
         end
         lhgg_pkg::ST_RENDER: begin
            if (status.out_free && status.last_seg) begin
               state_in = lhgg_pkg::ST_IDLE;
            end
         end
         default: state_in = lhgg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         lhgg_pkg::ST_IDLE: begin
            cmd.ready  = status.out_free;
            cmd.accept = status.out_free && req_tvalid;
         end
         lhgg_pkg::ST_RENDER: begin
            cmd.emit = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- src/lhgg_dp.sv -----
// Datapath for the layered hue gradient generator: settings, layer state,
// segment counter, key arithmetic and output register. Depends on lhgg_pkg.

module lhgg_dp #(
   parameter int LAYERS       = 2,
   parameter int MAX_SEGMENTS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [7:0]                csr_wdata,
   input  logic                      req_operation,
   input  logic [2:0]                req_layer,
   input  logic                      req_text_changed,
   input  logic [7:0]                req_key_code,
   input  logic                      rsp_tready,
   input  lhgg_pkg::ctrl_cmd_type    cmd,
   output lhgg_pkg::dp_status_type   status,
   output logic                      rsp_valid,
   output lhgg_pkg::rsp_payload_type rsp_payload
);

   localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int SEG_LIMIT = (MAX_SEGMENTS < lhgg_pkg::RESULT_CAP) ?
                              MAX_SEGMENTS : lhgg_pkg::RESULT_CAP;

   logic [5:0] num_segments_ff;
   logic [7:0] hue_key_step_ff;
   logic [7:0] level_key_step_ff;

   logic [7:0] hue_ff        [LAYERS];
   logic [7:0] saturation_ff [LAYERS];
   logic [7:0] brightness_ff [LAYERS];
   logic [7:0] stride_ff     [LAYERS];
   logic       frozen_ff;

   logic [LW-1:0] sel_ff;
   logic [7:0]    hue_acc_ff;
   logic [4:0]    seg_ff;
   logic [5:0]    count_ff;

   logic                      rsp_valid_ff;
   lhgg_pkg::rsp_payload_type rsp_ff;

   logic          layer_ok;
   logic [LW-1:0] li;
   logic          render_acc;
   logic          key_acc;
   logic          advance;
   logic [5:0]    seg_total;
   logic [7:0]    hue_start;
   logic          last_seg;

   logic [15:0] key_val;
   logic        key_known;
   logic        frozen_nx;
   logic        wr_hue, wr_sat, wr_brt, wr_stride;
   logic [7:0]  new_byte;

   assign layer_ok   = int'(req_layer) < LAYERS;
   assign li         = layer_ok ? LW'(req_layer) : '0;
   assign render_acc = cmd.accept && (req_operation == lhgg_pkg::OP_RENDER);
   assign key_acc    = cmd.accept && (req_operation == lhgg_pkg::OP_KEY);
   assign advance    = render_acc && req_text_changed && !frozen_ff;
   assign seg_total  = (num_segments_ff > 6'(SEG_LIMIT)) ? 6'(SEG_LIMIT) : num_segments_ff;
   assign hue_start  = hue_ff[li] + (advance ? stride_ff[li] : 8'd0);
   assign last_seg   = ({1'b0, seg_ff} + 6'd1) == count_ff;

   assign status.out_free  = !rsp_valid_ff || rsp_tready;
   assign status.render_go = (req_operation == lhgg_pkg::OP_RENDER) && layer_ok
                             && (seg_total != 6'd0);
   assign status.last_seg  = last_seg;

   always_comb begin
      key_val   = '0;
      key_known = 1'b1;
      frozen_nx = frozen_ff;
      wr_hue    = 1'b0;
      wr_sat    = 1'b0;
      wr_brt    = 1'b0;
      wr_stride = 1'b0;
      new_byte  = '0;
      if (req_key_code == lhgg_pkg::KEY_FREEZE) begin
         frozen_nx = !frozen_ff;
         key_val   = {15'd0, !frozen_ff};
      end else if (!layer_ok) begin
         key_known = 1'b0;
      end else begin
         case (req_key_code)
            lhgg_pkg::KEY_HUE_UP: begin
               new_byte = hue_ff[li] + hue_key_step_ff;
               wr_hue   = 1'b1;
            end
            lhgg_pkg::KEY_HUE_DOWN: begin
               new_byte = hue_ff[li] - hue_key_step_ff;
               wr_hue   = 1'b1;
            end
            lhgg_pkg::KEY_SAT_UP: begin
               new_byte = saturation_ff[li] + level_key_step_ff;
               wr_sat   = 1'b1;
            end
            lhgg_pkg::KEY_SAT_DOWN: begin
               new_byte = saturation_ff[li] - level_key_step_ff;
               wr_sat   = 1'b1;
            end
            lhgg_pkg::KEY_BRT_UP: begin
               new_byte = brightness_ff[li] + level_key_step_ff;
               wr_brt   = 1'b1;
            end
            lhgg_pkg::KEY_BRT_DOWN: begin
               new_byte = brightness_ff[li] - level_key_step_ff;
               wr_brt   = 1'b1;
            end
            lhgg_pkg::KEY_SHIFT_UP: begin
               new_byte = hue_ff[li] + stride_ff[li];
               wr_hue   = 1'b1;
            end
            lhgg_pkg::KEY_SHIFT_DN: begin
               new_byte = hue_ff[li] - stride_ff[li];
               wr_hue   = 1'b1;
            end
            lhgg_pkg::KEY_STRIDE_UP: begin
               new_byte  = stride_ff[li] + hue_key_step_ff;
               wr_stride = 1'b1;
            end
            lhgg_pkg::KEY_STRIDE_DN: begin
               new_byte  = stride_ff[li] - hue_key_step_ff;
               wr_stride = 1'b1;
            end
            default: key_known = 1'b0;
         endcase
         key_val = {8'd0, new_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_segments_ff   <= lhgg_pkg::NUM_SEGMENTS_RESET;
         hue_key_step_ff   <= lhgg_pkg::KEY_STEP_RESET;
         level_key_step_ff <= lhgg_pkg::KEY_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lhgg_pkg::REG_NUM_SEGMENTS:   num_segments_ff   <= csr_wdata[5:0];
            lhgg_pkg::REG_HUE_KEY_STEP:   hue_key_step_ff   <= csr_wdata;
            lhgg_pkg::REG_LEVEL_KEY_STEP: level_key_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LAYERS; l++) begin
            hue_ff[l]        <= 8'(l * lhgg_pkg::HUE_SPACING);
            saturation_ff[l] <= lhgg_pkg::LEVEL_RESET;
            brightness_ff[l] <= lhgg_pkg::LEVEL_RESET;
            stride_ff[l]     <= lhgg_pkg::STRIDE_RESET;
         end
         frozen_ff <= 1'b0;
      end else begin
         if (advance) begin
            for (int l = 0; l < LAYERS; l++) begin
               hue_ff[l] <= hue_ff[l] + stride_ff[l];
            end
         end
         if (key_acc) begin
            frozen_ff <= frozen_nx;
            if (wr_hue) begin
               hue_ff[li] <= new_byte;
            end
            if (wr_sat) begin
               saturation_ff[li] <= new_byte;
            end
            if (wr_brt) begin
               brightness_ff[li] <= new_byte;
            end
            if (wr_stride) begin
               stride_ff[li] <= new_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (render_acc) begin
         sel_ff     <= li;
         hue_acc_ff <= hue_start;
         seg_ff     <= '0;
         count_ff   <= seg_total;
      end else if (cmd.emit) begin
         hue_acc_ff <= hue_acc_ff + stride_ff[sel_ff];
         seg_ff     <= seg_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (key_acc || cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (key_acc) begin
         rsp_ff.kind          <= lhgg_pkg::KIND_KEY;
         rsp_ff.last          <= 1'b1;
         rsp_ff.segment_index <= '0;
         rsp_ff.hue           <= '0;
         rsp_ff.saturation    <= '0;
         rsp_ff.brightness    <= '0;
         rsp_ff.setting_value <= key_known ? key_val : lhgg_pkg::NO_SETTING;
         rsp_ff.key_known     <= key_known;
      end else if (cmd.emit) begin
         rsp_ff.kind          <= lhgg_pkg::KIND_COLOR;
         rsp_ff.last          <= last_seg;
         rsp_ff.segment_index <= seg_ff;
         rsp_ff.hue           <= hue_acc_ff;
         rsp_ff.saturation    <= saturation_ff[sel_ff];
         rsp_ff.brightness    <= brightness_ff[sel_ff];
         rsp_ff.setting_value <= '0;
         rsp_ff.key_known     <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- src/layered_hue_gradient_generator.sv -----
// Top level of the layered hue gradient generator.
// Instantiates lhgg_ctrl and lhgg_dp; depends on lhgg_pkg.

// A key item leaves a single acknowledgment in the output register. A render
// item is accepted first (the hue advance of all layers happens there) and
// then emits min(num_segments, MAX_SEGMENTS, 32) colors from the segment
// counter, one per cycle while the output is taken; the next item is accepted
// as the last color is handed over or after it. A render with zero segments
// or an out-of-range layer produces no transfer.

module layered_hue_gradient_generator #(
   parameter int LAYERS       = 2,
   parameter int MAX_SEGMENTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // layer[2:0], text_changed[3], key_code[11:4], zero
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // segment_index[4:0], hue[12:5], saturation[20:13],
                                    // brightness[28:21], setting_value[44:29],
                                    // key_known[45], zero
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast
);

   lhgg_pkg::ctrl_cmd_type    cmd;
   lhgg_pkg::dp_status_type   status;
   lhgg_pkg::rsp_payload_type rsp_payload;

   lhgg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   lhgg_dp #(
      .LAYERS       (LAYERS),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_operation    (req_tuser),
      .req_layer        (req_tdata[2:0]),
      .req_text_changed (req_tdata[3]),
      .req_key_code     (req_tdata[11:4]),
      .rsp_tready       (rsp_tready),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_tvalid),
      .rsp_payload      (rsp_payload)
   );

   assign req_tready = cmd.ready;
   assign rsp_tuser  = rsp_payload.kind;
   assign rsp_tlast  = rsp_payload.last;
   assign rsp_tdata  = {2'b00, rsp_payload.key_known, rsp_payload.setting_value,
                        rsp_payload.brightness, rsp_payload.saturation,
                        rsp_payload.hue, rsp_payload.segment_index};

`ifndef ASSERT_OFF
   a_key_ack: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == lhgg_pkg::OP_KEY
      |=> rsp_tvalid && rsp_tuser == lhgg_pkg::KIND_KEY && rsp_tlast)
      else $error("key transfer not acknowledged");

   a_seg_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == lhgg_pkg::KIND_COLOR && !rsp_tlast
      |=> rsp_tvalid && rsp_tuser == lhgg_pkg::KIND_COLOR
          && rsp_payload.segment_index == $past(rsp_payload.segment_index) + 5'd1)
      else $error("segment sequence broken");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lhgg_pkg::KIND_COLOR && !rsp_tlast |-> !req_tready)
      else $error("request taken during render");
`endif

endmodule
